>>> rtl/core/k_core_peel_max_core_macros.svh
//------------------------------------------------------------------------------
// k_core_peel_max_core_macros
// Assertion macros shared by the k-core peeling modules.
//------------------------------------------------------------------------------
`ifndef K_CORE_PEEL_MAX_CORE_MACROS_SVH
`define K_CORE_PEEL_MAX_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define KCPM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("k-core assertion failed");
// next-cycle implication, checked out of reset
`define KCPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("k-core assertion failed");
`else
`define KCPM_ASSERT_NOW(label, ante, cons)
`define KCPM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/core/k_cpm_pkg.sv
//------------------------------------------------------------------------------
// k_cpm_pkg
// Types and codes shared by the k-core peeling controller and datapath.
//------------------------------------------------------------------------------
package k_cpm_pkg;

    // item actions
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_RUN   = 2'd2;
    localparam logic [1:0] ACT_QUERY = 2'd3;

    // result status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_FULL     = 2'd1;
    localparam logic [1:0] STS_RANGE    = 2'd2;
    localparam logic [1:0] STS_NOT_DONE = 2'd3;

    localparam int          EDGE_W   = 20;
    localparam logic [12:0] CVAL_MAX = 13'h1FFF;

    typedef struct packed {
        logic [1:0] action;
        logic [9:0] end_a;
        logic [9:0] end_b;
        logic [9:0] probe_vertex;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [12:0] core_value;
        logic [10:0] core_size;
        logic        in_core;
    } t_result;

    // datapath commands, one per controller step
    typedef enum logic [4:0] {
        CMD_IDLE,
        CMD_ITEM,
        CMD_INIT,
        CMD_DEG_RD,
        CMD_DEG_RA,
        CMD_DEG_WA,
        CMD_DEG_RB,
        CMD_DEG_WB,
        CMD_SCAN_RD,
        CMD_SCAN_CHK,
        CMD_SCAN_NEXT,
        CMD_RM_RD,
        CMD_RM_EDGE,
        CMD_RM_UPD,
        CMD_MIN_RD,
        CMD_MIN_CHK,
        CMD_MIN_END,
        CMD_COPY_RD,
        CMD_COPY_WR,
        CMD_FIN
    } t_cmd;

    // datapath status back to the controller
    typedef struct packed {
        logic last_v;
        logic last_e;
        logic edge_empty;
        logic rm_hit;
        logic rm_match;
        logic found;
        logic cnt_zero;
    } t_dp_sts;

endpackage

>>> rtl/core/k_core_peel_max_core.sv
//------------------------------------------------------------------------------
// k_core_peel_max_core
// K-core peeling by degeneracy over a stored edge list, with queries.
//------------------------------------------------------------------------------
// Clear, add-edge and query items: one accepted per cycle while not busy, result in the next cycle.
// Run item: busy through an init pass over the vertices, a degree pass over the
//   edges, then repeated scan, min and core copy passes, the scans walking the
//   edge store once per removed vertex.
// Result strobe lasts one cycle; the receiver cannot stall.
// Reset: synchronous, active low; memories need no clearing pass.
module k_core_peel_max_core #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  k_cpm_pkg::t_item   i_item,
    output logic               o_res_valid,
    output k_cpm_pkg::t_result o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [10:0]        i_cfg_data
);

    k_cpm_pkg::t_cmd    w_cmd;
    k_cpm_pkg::t_dp_sts w_sts;

    // take configuration beats while idle
    assign o_cfg_ready = !busy;

    k_cpm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_item.action),
        .i_sts    (w_sts),
        .busy     (busy),
        .o_cmd    (w_cmd)
    );

    k_cpm_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_sts       (w_sts),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

endmodule

>>> rtl/core/k_cpm_dp.sv
//------------------------------------------------------------------------------
// k_cpm_dp
// Datapath: edge store, degree and flag memories, counters and result beat.
//------------------------------------------------------------------------------
module k_cpm_dp #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  k_cpm_pkg::t_cmd     i_cmd,
    input  k_cpm_pkg::t_item    i_item,
    input  logic                i_cfg_we,
    input  logic [10:0]         i_cfg_data,
    output k_cpm_pkg::t_dp_sts  o_sts,
    output logic                o_res_valid,
    output k_cpm_pkg::t_result  o_result
);
`include "k_core_peel_max_core_macros.svh"

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int VW1 = $clog2(MAX_VERTICES + 1);
    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ETW = $clog2(MAX_EDGES + 1);
    localparam int DW  = $clog2(2 * MAX_EDGES + 1);

    // memories
    logic [k_cpm_pkg::EDGE_W-1:0] r_edge_mem [MAX_EDGES];
    logic [DW-1:0]                r_deg_mem  [MAX_VERTICES];
    logic                         r_alive_mem[MAX_VERTICES];
    logic                         r_core_mem [MAX_VERTICES];

    logic [k_cpm_pkg::EDGE_W-1:0] r_edge_q;
    logic [DW-1:0]                r_deg_q;
    logic                         r_alive_q, r_core_q;

    // memory ports
    logic                         w_e_we, w_d_we, w_a_we, w_c_we;
    logic [EW-1:0]                w_e_waddr, w_e_raddr;
    logic [k_cpm_pkg::EDGE_W-1:0] w_e_wdata;
    logic [VW-1:0]                w_d_waddr, w_d_raddr, w_a_waddr, w_a_raddr;
    logic [VW-1:0]                w_c_waddr, w_c_raddr;
    logic [DW-1:0]                w_d_wdata;
    logic                         w_a_wdata, w_c_wdata;

    // registers
    logic [10:0]    r_vcount, n_vcount;
    logic [ETW-1:0] r_etotal, n_etotal;
    logic           r_computed, n_computed;
    logic [DW-1:0]  r_peel, n_peel;
    logic [VW1-1:0] r_ccount, n_ccount;
    logic [VW1-1:0] r_run_n, n_run_n;
    logic [VW-1:0]  r_vidx, n_vidx, r_cur, n_cur, r_other, n_other;
    logic [EW-1:0]  r_eidx, n_eidx;
    logic [VW-1:0]  r_ea, n_ea, r_eb, n_eb;
    logic           r_ev, n_ev;
    logic           r_found, n_found;
    logic           r_lvl_neg, n_lvl_neg;
    logic [DW-1:0]  r_level, n_level, r_min, n_min;
    logic [VW1-1:0] r_cnt, n_cnt;
    logic [9:0]     r_probe, n_probe;
    logic           r_valid, n_valid;
    logic [1:0]     r_status, n_status;
    logic [12:0]    r_cval, n_cval;
    logic [10:0]    r_csize, n_csize;
    logic           r_inc_sel, n_inc_sel;

    logic [VW1-1:0] w_n;
    logic           w_last_v, w_last_e, w_rm_hit, w_rm_match, w_edge_ok;
    logic [9:0]     w_qa, w_qb;
    logic [VW-1:0]  w_match_other;
    logic [DW-1:0]  w_lvl_out;

    // effective vertex count
    always_comb begin
        if (32'(r_vcount) > MAX_VERTICES) begin
            w_n = VW1'(MAX_VERTICES);
        end else if (r_vcount == 11'd0) begin
            w_n = VW1'(1);
        end else begin
            w_n = VW1'(r_vcount);
        end
    end

    // scan and edge status
    assign w_qa      = r_edge_q[9:0];
    assign w_qb      = r_edge_q[19:10];
    assign w_edge_ok = (32'(w_qa) < 32'(w_n)) && (32'(w_qb) < 32'(w_n));
    assign w_last_v  = (VW1'(r_vidx) == (w_n - VW1'(1)));
    assign w_last_e  = ((ETW'(r_eidx) + ETW'(1)) == r_etotal);
    assign w_rm_hit  = r_alive_q && !r_lvl_neg && (r_deg_q <= r_level);

    always_comb begin
        w_rm_match    = 1'b0;
        w_match_other = VW'(w_qb);
        if (w_edge_ok && (VW'(w_qa) == r_cur)) begin
            w_rm_match    = 1'b1;
            w_match_other = VW'(w_qb);
        end else if (w_edge_ok && (VW'(w_qb) == r_cur)) begin
            w_rm_match    = 1'b1;
            w_match_other = VW'(w_qa);
        end
    end

    assign w_lvl_out = r_lvl_neg ? '0 : r_level;

    assign o_sts.last_v     = w_last_v;
    assign o_sts.last_e     = w_last_e;
    assign o_sts.edge_empty = (r_etotal == '0);
    assign o_sts.rm_hit     = w_rm_hit;
    assign o_sts.rm_match   = w_rm_match;
    assign o_sts.found      = r_found;
    assign o_sts.cnt_zero   = (r_cnt == '0);

    // command decode
    always_comb begin
        w_e_we = 1'b0; w_e_waddr = '0; w_e_wdata = '0; w_e_raddr = r_eidx;
        w_d_we = 1'b0; w_d_waddr = '0; w_d_wdata = '0; w_d_raddr = r_vidx;
        w_a_we = 1'b0; w_a_waddr = '0; w_a_wdata = 1'b0; w_a_raddr = r_vidx;
        w_c_we = 1'b0; w_c_waddr = '0; w_c_wdata = 1'b0; w_c_raddr = VW'(r_probe);

        n_vcount = i_cfg_we ? i_cfg_data : r_vcount;
        n_etotal = r_etotal;   n_computed = r_computed; n_peel = r_peel;
        n_ccount = r_ccount;   n_vidx = r_vidx;         n_cur = r_cur;
        n_other = r_other;     n_eidx = r_eidx;         n_ea = r_ea;
        n_eb = r_eb;           n_ev = r_ev;             n_found = r_found;
        n_lvl_neg = r_lvl_neg; n_level = r_level;       n_min = r_min;
        n_cnt = r_cnt;         n_probe = r_probe;       n_run_n = r_run_n;
        n_valid = 1'b0;        n_status = r_status;     n_cval = r_cval;
        n_csize = r_csize;     n_inc_sel = r_inc_sel;

        case (i_cmd)
            k_cpm_pkg::CMD_ITEM: begin
                n_probe   = i_item.probe_vertex;
                w_c_raddr = VW'(i_item.probe_vertex);
                n_vidx    = '0;
                n_status  = k_cpm_pkg::STS_OK;
                n_cval    = '0;
                n_csize   = '0;
                n_inc_sel = 1'b0;
                n_valid   = (i_item.action != k_cpm_pkg::ACT_RUN);
                case (i_item.action)
                    k_cpm_pkg::ACT_CLEAR: begin
                        n_etotal   = '0;
                        n_computed = 1'b0;
                        n_peel     = '0;
                        n_ccount   = '0;
                    end
                    k_cpm_pkg::ACT_ADD: begin
                        if ((32'(i_item.end_a) >= 32'(w_n)) ||
                            (32'(i_item.end_b) >= 32'(w_n))) begin
                            n_status = k_cpm_pkg::STS_RANGE;
                        end else if (32'(r_etotal) >= MAX_EDGES) begin
                            n_status = k_cpm_pkg::STS_FULL;
                        end else begin
                            w_e_we    = 1'b1;
                            w_e_waddr = EW'(r_etotal);
                            w_e_wdata = {i_item.end_b, i_item.end_a};
                            n_etotal  = r_etotal + ETW'(1);
                        end
                    end
                    k_cpm_pkg::ACT_QUERY: begin
                        if (!r_computed) begin
                            n_status = k_cpm_pkg::STS_NOT_DONE;
                        end else begin
                            n_cval    = (32'(r_peel) > 32'(k_cpm_pkg::CVAL_MAX)) ?
                                        k_cpm_pkg::CVAL_MAX : 13'(r_peel);
                            n_csize   = 11'(r_ccount);
                            // vertices beyond the last run's count were never in the core
                            n_inc_sel = (32'(i_item.probe_vertex) < 32'(w_n)) &&
                                        (32'(i_item.probe_vertex) < 32'(r_run_n));
                            if (32'(i_item.probe_vertex) >= 32'(w_n)) begin
                                n_status = k_cpm_pkg::STS_RANGE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            k_cpm_pkg::CMD_INIT: begin
                w_d_we = 1'b1; w_d_waddr = r_vidx; w_d_wdata = '0;
                w_a_we = 1'b1; w_a_waddr = r_vidx; w_a_wdata = 1'b1;
                w_c_we = 1'b1; w_c_waddr = r_vidx; w_c_wdata = 1'b0;
                n_vidx    = w_last_v ? '0 : r_vidx + VW'(1);
                n_eidx    = '0;
                n_found   = 1'b0;
                n_lvl_neg = 1'b1;
                n_level   = '0;
                n_ccount  = '0;
            end
            k_cpm_pkg::CMD_DEG_RA: begin
                n_ea = VW'(w_qa);
                n_eb = VW'(w_qb);
                n_ev = w_edge_ok;
                w_d_raddr = VW'(w_qa);
            end
            k_cpm_pkg::CMD_DEG_WA: begin
                w_d_we = r_ev; w_d_waddr = r_ea; w_d_wdata = r_deg_q + DW'(1);
            end
            k_cpm_pkg::CMD_DEG_RB: begin
                w_d_raddr = r_eb;
            end
            k_cpm_pkg::CMD_DEG_WB: begin
                w_d_we = r_ev; w_d_waddr = r_eb; w_d_wdata = r_deg_q + DW'(1);
                n_eidx = w_last_e ? '0 : r_eidx + EW'(1);
            end
            k_cpm_pkg::CMD_SCAN_CHK: begin
                if (w_rm_hit) begin
                    w_a_we = 1'b1; w_a_waddr = r_vidx; w_a_wdata = 1'b0;
                    n_cur   = r_vidx;
                    n_found = 1'b1;
                    n_eidx  = '0;
                end
            end
            k_cpm_pkg::CMD_SCAN_NEXT: begin
                if (w_last_v) begin
                    n_vidx  = '0;
                    n_found = 1'b0;
                    n_cnt   = '0;
                    n_min   = '0;
                end else begin
                    n_vidx = r_vidx + VW'(1);
                end
            end
            k_cpm_pkg::CMD_RM_EDGE: begin
                if (w_rm_match) begin
                    n_other   = w_match_other;
                    w_a_raddr = w_match_other;
                    w_d_raddr = w_match_other;
                end else begin
                    n_eidx = w_last_e ? '0 : r_eidx + EW'(1);
                end
            end
            k_cpm_pkg::CMD_RM_UPD: begin
                w_d_we    = r_alive_q && (r_deg_q != '0);
                w_d_waddr = r_other;
                w_d_wdata = r_deg_q - DW'(1);
                n_eidx    = w_last_e ? '0 : r_eidx + EW'(1);
            end
            k_cpm_pkg::CMD_MIN_CHK: begin
                if (r_alive_q) begin
                    n_cnt = r_cnt + VW1'(1);
                    if ((r_cnt == '0) || (r_deg_q < r_min)) begin
                        n_min = r_deg_q;
                    end
                end
                n_vidx = w_last_v ? '0 : r_vidx + VW'(1);
            end
            k_cpm_pkg::CMD_MIN_END: begin
                if (r_cnt != '0) begin
                    n_level   = r_min;
                    n_lvl_neg = 1'b0;
                    n_ccount  = r_cnt;
                end
            end
            k_cpm_pkg::CMD_COPY_WR: begin
                w_c_we = 1'b1; w_c_waddr = r_vidx; w_c_wdata = r_alive_q;
                if (w_last_v) begin
                    n_vidx  = '0;
                    n_found = 1'b0;
                end else begin
                    n_vidx = r_vidx + VW'(1);
                end
            end
            k_cpm_pkg::CMD_FIN: begin
                n_peel     = w_lvl_out;
                n_computed = 1'b1;
                n_run_n    = w_n;
                n_valid    = 1'b1;
                n_status   = k_cpm_pkg::STS_OK;
                n_cval     = (32'(w_lvl_out) > 32'(k_cpm_pkg::CVAL_MAX)) ?
                             k_cpm_pkg::CVAL_MAX : 13'(w_lvl_out);
                n_csize    = 11'(r_ccount);
                n_inc_sel  = (32'(r_probe) < 32'(w_n));
            end
            default: begin
            end
        endcase
    end

    // edge store
    always_ff @(posedge i_clk) begin
        if (w_e_we) begin
            r_edge_mem[w_e_waddr] <= w_e_wdata;
        end
        r_edge_q <= r_edge_mem[w_e_raddr];
    end

    // remaining degree
    always_ff @(posedge i_clk) begin
        if (w_d_we) begin
            r_deg_mem[w_d_waddr] <= w_d_wdata;
        end
        r_deg_q <= r_deg_mem[w_d_raddr];
    end

    // live flags
    always_ff @(posedge i_clk) begin
        if (w_a_we) begin
            r_alive_mem[w_a_waddr] <= w_a_wdata;
        end
        r_alive_q <= r_alive_mem[w_a_raddr];
    end

    // core membership
    always_ff @(posedge i_clk) begin
        if (w_c_we) begin
            r_core_mem[w_c_waddr] <= w_c_wdata;
        end
        r_core_q <= r_core_mem[w_c_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount   <= 11'd1;
            r_etotal   <= '0;
            r_computed <= 1'b0;
            r_peel     <= '0;
            r_ccount   <= '0;
            r_run_n    <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_vcount   <= n_vcount;
            r_etotal   <= n_etotal;
            r_computed <= n_computed;
            r_peel     <= n_peel;
            r_ccount   <= n_ccount;
            r_run_n    <= n_run_n;
            r_valid    <= n_valid;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_vidx <= n_vidx;       r_cur <= n_cur;         r_other <= n_other;
        r_eidx <= n_eidx;       r_ea <= n_ea;           r_eb <= n_eb;
        r_ev <= n_ev;           r_found <= n_found;     r_lvl_neg <= n_lvl_neg;
        r_level <= n_level;     r_min <= n_min;         r_cnt <= n_cnt;
        r_probe <= n_probe;     r_status <= n_status;   r_cval <= n_cval;
        r_csize <= n_csize;     r_inc_sel <= n_inc_sel;
    end

    // result beat
    assign o_res_valid         = r_valid;
    assign o_result.status     = r_status;
    assign o_result.core_value = r_cval;
    assign o_result.core_size  = r_csize;
    assign o_result.in_core    = r_inc_sel & r_core_q;

    `KCPM_ASSERT_NEXT(a_item_beat, (i_cmd == k_cpm_pkg::CMD_ITEM) && (i_item.action != k_cpm_pkg::ACT_RUN), r_valid)
    `KCPM_ASSERT_NOW(a_no_rm_below_zero, (i_cmd == k_cpm_pkg::CMD_SCAN_CHK) && r_lvl_neg, !w_rm_hit)
    `KCPM_ASSERT_NEXT(a_level_set, (i_cmd == k_cpm_pkg::CMD_MIN_END) && (r_cnt != '0), !r_lvl_neg)

endmodule

>>> rtl/core/k_cpm_ctrl.sv
//------------------------------------------------------------------------------
// k_cpm_ctrl
// Controller: sequences item handling and the peeling walk.
//------------------------------------------------------------------------------
module k_cpm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [1:0]         i_action,
    input  k_cpm_pkg::t_dp_sts i_sts,
    output logic               busy,
    output k_cpm_pkg::t_cmd    o_cmd
);
`include "k_core_peel_max_core_macros.svh"

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_DEG_RD, S_DEG_RA, S_DEG_WA, S_DEG_RB, S_DEG_WB,
        S_SCAN_RD, S_SCAN_CHK, S_SCAN_NEXT, S_RM_RD, S_RM_EDGE, S_RM_UPD,
        S_MIN_RD, S_MIN_CHK, S_MIN_END, S_COPY_RD, S_COPY_WR, S_FIN
    } t_state;

    t_state r_state, n_state;

    assign busy = (r_state != S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (start && (i_action == k_cpm_pkg::ACT_RUN)) n_state = S_INIT;
            S_INIT:      if (i_sts.last_v) n_state = i_sts.edge_empty ? S_SCAN_RD : S_DEG_RD;
            S_DEG_RD:    n_state = S_DEG_RA;
            S_DEG_RA:    n_state = S_DEG_WA;
            S_DEG_WA:    n_state = S_DEG_RB;
            S_DEG_RB:    n_state = S_DEG_WB;
            S_DEG_WB:    n_state = i_sts.last_e ? S_SCAN_RD : S_DEG_RD;
            S_SCAN_RD:   n_state = S_SCAN_CHK;
            S_SCAN_CHK:  n_state = (i_sts.rm_hit && !i_sts.edge_empty) ? S_RM_RD : S_SCAN_NEXT;
            S_SCAN_NEXT: begin
                if (!i_sts.last_v || i_sts.found) n_state = S_SCAN_RD;
                else n_state = S_MIN_RD;
            end
            S_RM_RD:     n_state = S_RM_EDGE;
            S_RM_EDGE: begin
                if (i_sts.rm_match) n_state = S_RM_UPD;
                else n_state = i_sts.last_e ? S_SCAN_NEXT : S_RM_RD;
            end
            S_RM_UPD:    n_state = i_sts.last_e ? S_SCAN_NEXT : S_RM_RD;
            S_MIN_RD:    n_state = S_MIN_CHK;
            S_MIN_CHK:   n_state = i_sts.last_v ? S_MIN_END : S_MIN_RD;
            S_MIN_END:   n_state = i_sts.cnt_zero ? S_FIN : S_COPY_RD;
            S_COPY_RD:   n_state = S_COPY_WR;
            S_COPY_WR:   n_state = i_sts.last_v ? S_SCAN_RD : S_COPY_RD;
            S_FIN:       n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // command to datapath
    always_comb begin
        case (r_state)
            S_IDLE:      o_cmd = start ? k_cpm_pkg::CMD_ITEM : k_cpm_pkg::CMD_IDLE;
            S_INIT:      o_cmd = k_cpm_pkg::CMD_INIT;
            S_DEG_RD:    o_cmd = k_cpm_pkg::CMD_DEG_RD;
            S_DEG_RA:    o_cmd = k_cpm_pkg::CMD_DEG_RA;
            S_DEG_WA:    o_cmd = k_cpm_pkg::CMD_DEG_WA;
            S_DEG_RB:    o_cmd = k_cpm_pkg::CMD_DEG_RB;
            S_DEG_WB:    o_cmd = k_cpm_pkg::CMD_DEG_WB;
            S_SCAN_RD:   o_cmd = k_cpm_pkg::CMD_SCAN_RD;
            S_SCAN_CHK:  o_cmd = k_cpm_pkg::CMD_SCAN_CHK;
            S_SCAN_NEXT: o_cmd = k_cpm_pkg::CMD_SCAN_NEXT;
            S_RM_RD:     o_cmd = k_cpm_pkg::CMD_RM_RD;
            S_RM_EDGE:   o_cmd = k_cpm_pkg::CMD_RM_EDGE;
            S_RM_UPD:    o_cmd = k_cpm_pkg::CMD_RM_UPD;
            S_MIN_RD:    o_cmd = k_cpm_pkg::CMD_MIN_RD;
            S_MIN_CHK:   o_cmd = k_cpm_pkg::CMD_MIN_CHK;
            S_MIN_END:   o_cmd = k_cpm_pkg::CMD_MIN_END;
            S_COPY_RD:   o_cmd = k_cpm_pkg::CMD_COPY_RD;
            S_COPY_WR:   o_cmd = k_cpm_pkg::CMD_COPY_WR;
            S_FIN:       o_cmd = k_cpm_pkg::CMD_FIN;
            default:     o_cmd = k_cpm_pkg::CMD_IDLE;
        endcase
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `KCPM_ASSERT_NEXT(a_run_busy, start && !busy && (i_action == k_cpm_pkg::ACT_RUN), busy)
    `KCPM_ASSERT_NEXT(a_item_free, start && !busy && (i_action != k_cpm_pkg::ACT_RUN), !busy)
    `KCPM_ASSERT_NEXT(a_fin_idle, r_state == S_FIN, r_state == S_IDLE)

endmodule
